// ----- rtl/qwag_pkg.sv -----
// shared constants and types for the quad warp address generator
package qwag_pkg;

  localparam int unsigned IN_WIDTH        = 640;
  localparam int unsigned IN_HEIGHT       = 480;
  localparam int unsigned OUT_WIDTH       = 640;
  localparam int unsigned OUT_HEIGHT      = 480;
  localparam int unsigned BYTES_PER_PIXEL = 1;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int CX_W    = 10;
  localparam int CY_W    = 9;
  localparam int IDX_W   = 19;
  localparam int FRAC_W  = 16;
  localparam int DIM_W   = 13;
  localparam int WIDE_W  = 32;
  localparam int RECIP_W = 33;
  localparam int PROD_W  = RECIP_W + COL_W;
  localparam int LERP_W  = CX_W + FRAC_W;
  localparam int ACC_W   = CX_W + 2 * FRAC_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [FRAC_W:0] W_ONE = {1'b1, {FRAC_W{1'b0}}};

  localparam longint unsigned RECIP_NUM = 64'd1 << (2 * FRAC_W);
  localparam logic [RECIP_W-1:0] RECIP_COL = RECIP_W'(RECIP_NUM / 64'(OUT_WIDTH));
  localparam logic [RECIP_W-1:0] RECIP_ROW = RECIP_W'(RECIP_NUM / 64'(OUT_HEIGHT));

  localparam logic [DIM_W-1:0] COL_MAX = DIM_W'(OUT_WIDTH - 1);
  localparam logic [DIM_W-1:0] ROW_MAX = DIM_W'(OUT_HEIGHT - 1);
  localparam logic [DIM_W-1:0] SX_MAX  = DIM_W'(IN_WIDTH - 1);
  localparam logic [DIM_W-1:0] SY_MAX  = DIM_W'(IN_HEIGHT - 1);

  localparam logic [WIDE_W-1:0] BPP        = WIDE_W'(BYTES_PER_PIXEL);
  localparam logic [WIDE_W-1:0] SRC_STRIDE = WIDE_W'(IN_WIDTH * BYTES_PER_PIXEL);
  localparam logic [WIDE_W-1:0] DST_STRIDE = WIDE_W'(OUT_WIDTH * BYTES_PER_PIXEL);

  localparam logic [CX_W-1:0] TL_X_RST = CX_W'(0);
  localparam logic [CY_W-1:0] TL_Y_RST = CY_W'(0);
  localparam logic [CX_W-1:0] TR_X_RST = CX_W'(639);
  localparam logic [CY_W-1:0] TR_Y_RST = CY_W'(0);
  localparam logic [CX_W-1:0] BR_X_RST = CX_W'(639);
  localparam logic [CY_W-1:0] BR_Y_RST = CY_W'(479);
  localparam logic [CX_W-1:0] BL_X_RST = CX_W'(0);
  localparam logic [CY_W-1:0] BL_Y_RST = CY_W'(479);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TL_X = 4'd0,
    REG_TL_Y = 4'd1,
    REG_TR_X = 4'd2,
    REG_TR_Y = 4'd3,
    REG_BR_X = 4'd4,
    REG_BR_Y = 4'd5,
    REG_BL_X = 4'd6,
    REG_BL_Y = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic ld_edge;
    logic ld_acc;
  } lerp_en_t;

endpackage

// ----- rtl/qwag_bilerp.sv -----
// two-stage bilinear interpolation of one coordinate of the four corners
module qwag_bilerp (
  input  logic                        clk_i,
  input  qwag_pkg::lerp_en_t          en_i,
  input  logic [qwag_pkg::FRAC_W-1:0] u_i,
  input  logic [qwag_pkg::FRAC_W-1:0] v_i,
  input  logic [qwag_pkg::CX_W-1:0]   tl_i,
  input  logic [qwag_pkg::CX_W-1:0]   tr_i,
  input  logic [qwag_pkg::CX_W-1:0]   br_i,
  input  logic [qwag_pkg::CX_W-1:0]   bl_i,
  output logic [qwag_pkg::CX_W-1:0]   coord_o
);
  import qwag_pkg::*;

  logic [LERP_W-1:0] top_d, top_q, bot_d, bot_q;
  logic [FRAC_W-1:0] v_q;
  logic [ACC_W-1:0]  acc_d;
  logic [CX_W-1:0]   coord_q;
  logic [FRAC_W:0]   u_inv, v_inv;

  always_comb begin
    u_inv = W_ONE - (FRAC_W + 1)'(u_i);
    top_d = LERP_W'(LERP_W'(tl_i) * LERP_W'(u_inv) + LERP_W'(tr_i) * LERP_W'(u_i));
    bot_d = LERP_W'(LERP_W'(bl_i) * LERP_W'(u_inv) + LERP_W'(br_i) * LERP_W'(u_i));
    v_inv = W_ONE - (FRAC_W + 1)'(v_q);
    acc_d = ACC_W'(ACC_W'(top_q) * ACC_W'(v_inv) + ACC_W'(bot_q) * ACC_W'(v_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_edge) begin
      top_q <= top_d;
      bot_q <= bot_d;
      v_q   <= v_i;
    end
    if (en_i.ld_acc) begin
      coord_q <= acc_d[ACC_W-1:2*FRAC_W];
    end
  end

  assign coord_o = coord_q;

endmodule

// ----- rtl/quad_warp_address_generator.sv -----
// quad warp address generator: six-stage pipeline
// takes one item per cycle; each stage holds its item while the next cannot take it
// stages: weight estimate, weight correction, edge lerp, vertical lerp,
// source clamp, index forming; the multipliers of the two lerp stages set the depth
// reset: corner registers return to their defaults and all stages empty
module quad_warp_address_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qwag_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [qwag_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // out_col [9:0], out_row [18:10], zero [23:19]
  input  logic [qwag_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // source_byte_index [18:0], dest_byte_index [37:19], zero [39:38]
  output logic [qwag_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import qwag_pkg::*;

  localparam int NSTG = 6;

  logic [CX_W-1:0] tl_x_q, tr_x_q, br_x_q, bl_x_q;
  logic [CY_W-1:0] tl_y_q, tr_y_q, br_y_q, bl_y_q;

  logic [NSTG:1]   vld_q;
  logic [NSTG+1:1] rdy;
  logic [NSTG-1:0] vin;

  logic [COL_W-1:0]  in_col, col_c, col_q;
  logic [ROW_W-1:0]  in_row, row_c, row_q;
  logic [PROD_W-1:0] u_prod, v_prod;
  logic [FRAC_W-1:0] u_est_q, v_est_q, u_d, v_d, u_q, v_q;
  logic [WIDE_W-1:0] u_rem, v_rem, dst_full;

  logic [IDX_W-1:0] dst2_q, dst3_q, dst4_q, dst5_q, dst6_q, src6_q;
  logic [CX_W-1:0]  sx_raw, sy_raw;
  logic [CX_W-1:0]  sx_q;
  logic [CY_W-1:0]  sy_q;
  logic [CX_W-1:0]  sx_c;
  logic [CY_W-1:0]  sy_c;
  logic [WIDE_W-1:0] src_full;

  lerp_en_t lerp_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_x_q <= TL_X_RST;
      tl_y_q <= TL_Y_RST;
      tr_x_q <= TR_X_RST;
      tr_y_q <= TR_Y_RST;
      br_x_q <= BR_X_RST;
      br_y_q <= BR_Y_RST;
      bl_x_q <= BL_X_RST;
      bl_y_q <= BL_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TL_X: tl_x_q <= cfg_wdata_i[CX_W-1:0];
        REG_TL_Y: tl_y_q <= cfg_wdata_i[CY_W-1:0];
        REG_TR_X: tr_x_q <= cfg_wdata_i[CX_W-1:0];
        REG_TR_Y: tr_y_q <= cfg_wdata_i[CY_W-1:0];
        REG_BR_X: br_x_q <= cfg_wdata_i[CX_W-1:0];
        REG_BR_Y: br_y_q <= cfg_wdata_i[CY_W-1:0];
        REG_BL_X: bl_x_q <= cfg_wdata_i[CX_W-1:0];
        REG_BL_Y: bl_y_q <= cfg_wdata_i[CY_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin[0] = s_axis_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      vin[k] = vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[1];

  // stage 1: clamp coordinates, estimate weights by reciprocal
  always_comb begin
    in_col = s_axis_tdata[COL_W-1:0];
    in_row = s_axis_tdata[COL_W+ROW_W-1:COL_W];
    col_c  = (DIM_W'(in_col) > COL_MAX) ? COL_MAX[COL_W-1:0] : in_col;
    row_c  = (DIM_W'(in_row) > ROW_MAX) ? ROW_MAX[ROW_W-1:0] : in_row;
    u_prod = PROD_W'(col_c) * PROD_W'(RECIP_COL);
    v_prod = PROD_W'(row_c) * PROD_W'(RECIP_ROW);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      col_q   <= col_c;
      row_q   <= row_c;
      u_est_q <= u_prod[2*FRAC_W-1:FRAC_W];
      v_est_q <= v_prod[2*FRAC_W-1:FRAC_W];
    end
  end

  // stage 2: correct weights by one, form destination index
  always_comb begin
    u_rem = (WIDE_W'(col_q) << FRAC_W) - WIDE_W'(u_est_q) * WIDE_W'(OUT_WIDTH);
    v_rem = (WIDE_W'(row_q) << FRAC_W) - WIDE_W'(v_est_q) * WIDE_W'(OUT_HEIGHT);
    u_d   = (u_rem >= WIDE_W'(OUT_WIDTH))  ? u_est_q + 1'b1 : u_est_q;
    v_d   = (v_rem >= WIDE_W'(OUT_HEIGHT)) ? v_est_q + 1'b1 : v_est_q;
    dst_full = WIDE_W'(col_q) * BPP + WIDE_W'(row_q) * DST_STRIDE;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      u_q    <= u_d;
      v_q    <= v_d;
      dst2_q <= dst_full[IDX_W-1:0];
    end
  end

  // stages 3 and 4: interpolation
  assign lerp_en.ld_edge = rdy[3];
  assign lerp_en.ld_acc  = rdy[4];

  qwag_bilerp u_lerp_x (
    .clk_i   (clk_i),
    .en_i    (lerp_en),
    .u_i     (u_q),
    .v_i     (v_q),
    .tl_i    (tl_x_q),
    .tr_i    (tr_x_q),
    .br_i    (br_x_q),
    .bl_i    (bl_x_q),
    .coord_o (sx_raw)
  );

  qwag_bilerp u_lerp_y (
    .clk_i   (clk_i),
    .en_i    (lerp_en),
    .u_i     (u_q),
    .v_i     (v_q),
    .tl_i    (CX_W'(tl_y_q)),
    .tr_i    (CX_W'(tr_y_q)),
    .br_i    (CX_W'(br_y_q)),
    .bl_i    (CX_W'(bl_y_q)),
    .coord_o (sy_raw)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      dst3_q <= dst2_q;
    end
    if (rdy[4]) begin
      dst4_q <= dst3_q;
    end
  end

  // stage 5: clamp source coordinates to the input frame
  always_comb begin
    sx_c = (DIM_W'(sx_raw) > SX_MAX) ? SX_MAX[CX_W-1:0] : sx_raw;
    sy_c = (DIM_W'(sy_raw) > SY_MAX) ? SY_MAX[CY_W-1:0] : sy_raw[CY_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      sx_q   <= sx_c;
      sy_q   <= sy_c;
      dst5_q <= dst4_q;
    end
  end

  // stage 6: source index, output register
  assign src_full = WIDE_W'(sx_q) * BPP + WIDE_W'(sy_q) * SRC_STRIDE;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      src6_q <= src_full[IDX_W-1:0];
      dst6_q <= dst5_q;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = {(OUT_TDATA_W - 2 * IDX_W)'(0), dst6_q, src6_q};

endmodule

// ----- test/warp_index_checker.sv -----
// checker that predicts source and destination byte indices and compares them
`timescale 1ns / 1ps

module warp_index_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qwag_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [qwag_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // out_col, out_row, zero
  input  logic [qwag_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // source_byte_index, dest_byte_index, zero
  input  logic [qwag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                               mismatch_count_o,
  output int                               outstanding_o
);
  import qwag_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] dst_index;
    logic [IDX_W-1:0] src_index;
  } warp_indices_t;

  warp_indices_t expected_indices[$];
  int            mismatches = 0;

  logic [CX_W-1:0] tl_x, tr_x, br_x, bl_x;
  logic [CY_W-1:0] tl_y, tr_y, br_y, bl_y;

  function automatic longint unsigned blend_corners(
    input longint unsigned tl, input longint unsigned tr,
    input longint unsigned br, input longint unsigned bl,
    input longint unsigned u,  input longint unsigned v
  );
    longint unsigned one, top_edge, bottom_edge;
    one         = longint'(W_ONE);
    top_edge    = tl * (one - u) + tr * u;
    bottom_edge = bl * (one - u) + br * u;
    return (top_edge * (one - v) + bottom_edge * v) >> (2 * FRAC_W);
  endfunction

  function automatic warp_indices_t warp_indices(
    input logic [COL_W-1:0] col_in,
    input logic [ROW_W-1:0] row_in
  );
    longint unsigned col, row, u, v, sx, sy;
    warp_indices_t   res;
    col = col_in;
    row = row_in;
    if (col > OUT_WIDTH - 1) col = OUT_WIDTH - 1;
    if (row > OUT_HEIGHT - 1) row = OUT_HEIGHT - 1;
    u  = (col << FRAC_W) / OUT_WIDTH;
    v  = (row << FRAC_W) / OUT_HEIGHT;
    sx = blend_corners(tl_x, tr_x, br_x, bl_x, u, v);
    sy = blend_corners(tl_y, tr_y, br_y, bl_y, u, v);
    if (sx > IN_WIDTH - 1) sx = IN_WIDTH - 1;
    if (sy > IN_HEIGHT - 1) sy = IN_HEIGHT - 1;
    res.src_index = IDX_W'((sx + sy * IN_WIDTH) * BYTES_PER_PIXEL);
    res.dst_index = IDX_W'((col + row * OUT_WIDTH) * BYTES_PER_PIXEL);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_items
    warp_indices_t got, want;
    if (!rst_ni) begin
      tl_x = TL_X_RST;
      tl_y = TL_Y_RST;
      tr_x = TR_X_RST;
      tr_y = TR_Y_RST;
      br_x = BR_X_RST;
      br_y = BR_Y_RST;
      bl_x = BL_X_RST;
      bl_y = BL_Y_RST;
      expected_indices.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*IDX_W-1:0];
        if (expected_indices.size() == 0) begin
          $display("%0t: unexpected item, expected none, got src %0d dst %0d",
                   $time, got.src_index, got.dst_index);
          mismatches++;
        end else begin
          want = expected_indices.pop_front();
          if (got.src_index !== want.src_index) begin
            $display("%0t: source index expected %0d, got %0d",
                     $time, want.src_index, got.src_index);
            mismatches++;
          end
          if (got.dst_index !== want.dst_index) begin
            $display("%0t: dest index expected %0d, got %0d",
                     $time, want.dst_index, got.dst_index);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_indices.push_back(warp_indices(s_axis_tdata[COL_W-1:0],
                                                s_axis_tdata[COL_W+ROW_W-1:COL_W]));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_TL_X: tl_x = cfg_wdata_i[CX_W-1:0];
          REG_TL_Y: tl_y = cfg_wdata_i[CY_W-1:0];
          REG_TR_X: tr_x = cfg_wdata_i[CX_W-1:0];
          REG_TR_Y: tr_y = cfg_wdata_i[CY_W-1:0];
          REG_BR_X: br_x = cfg_wdata_i[CX_W-1:0];
          REG_BR_Y: br_y = cfg_wdata_i[CY_W-1:0];
          REG_BL_X: bl_x = cfg_wdata_i[CX_W-1:0];
          REG_BL_Y: bl_y = cfg_wdata_i[CY_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding_o    <= expected_indices.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- test/testbench.sv -----
// top of the quad warp address generator test: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import qwag_pkg::*;

  localparam int LATENCY         = 6;
  localparam int NUM_CORNER_REGS = 8;
  localparam int PHASE_ITEMS     = 200;
  localparam int FIRST_HOLD_AT   = 150;
  localparam int SECOND_HOLD_AT  = 900;
  localparam int HOLD_CYCLES     = 64;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     mismatch_count;
  int                     outstanding;
  logic                   quiet = 1'b0;

  quad_warp_address_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  warp_index_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [NUM_CORNER_REGS*CFG_DATA_W-1:0] pack_corners(
    input int tlx, input int tly, input int trx, input int try_y,
    input int brx, input int bry, input int blx, input int bly
  );
    return {CFG_DATA_W'(bly), CFG_DATA_W'(blx), CFG_DATA_W'(bry), CFG_DATA_W'(brx),
            CFG_DATA_W'(try_y), CFG_DATA_W'(trx), CFG_DATA_W'(tly), CFG_DATA_W'(tlx)};
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // writes happen only with the pipeline drained
  task automatic load_corners(input logic [NUM_CORNER_REGS*CFG_DATA_W-1:0] values);
    int i;
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    for (i = 0; i < NUM_CORNER_REGS; i++) begin
      write_reg(CFG_ADDR_W'(i), values[i*CFG_DATA_W +: CFG_DATA_W]);
    end
    // unmapped index must be ignored
    write_reg(CFG_ADDR_W'(NUM_CORNER_REGS + $urandom_range(0, NUM_CORNER_REGS - 1)),
              CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({row, col});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_item();
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom)
                                      : COL_W'($urandom_range(0, OUT_WIDTH - 1));
    row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom)
                                      : ROW_W'($urandom_range(0, OUT_HEIGHT - 1));
    send_item(col, row);
  endtask

  initial begin : drain_results
    int drained, stall_left, holds_done;
    drained    = 0;
    stall_left = 0;
    holds_done = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) drained++;
      if (stall_left > 0) begin
        stall_left--;
      end else if (holds_done < 2 &&
                   drained >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
        stall_left = HOLD_CYCLES;
        holds_done++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin : make_stimulus
    int phase, n;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, edges and out-of-range coordinates under reset corners
    send_item(COL_W'(0), ROW_W'(0));
    send_item(COL_W'(639), ROW_W'(0));
    send_item(COL_W'(0), ROW_W'(479));
    send_item(COL_W'(639), ROW_W'(479));
    send_item(COL_W'(1023), ROW_W'(511));
    send_item(COL_W'(640), ROW_W'(480));
    send_item(COL_W'(1023), ROW_W'(0));
    send_item(COL_W'(0), ROW_W'(511));
    send_item(COL_W'(1), ROW_W'(1));
    send_item(COL_W'(320), ROW_W'(240));
    send_item(COL_W'(512), ROW_W'(256));
    send_item(COL_W'(638), ROW_W'(478));
    send_item(COL_W'(341), ROW_W'(170));
    send_item(COL_W'(682), ROW_W'(100));
    send_item(COL_W'(100), ROW_W'(400));
    send_item(COL_W'(1023), ROW_W'(479));
    for (n = 0; n < PHASE_ITEMS - 16; n++) send_random_item();

    for (phase = 1; phase < 8; phase++) begin
      case (phase)
        1: load_corners('0);
        2: load_corners('1);
        3: load_corners(pack_corners(639, 479, 0, 479, 0, 0, 639, 0));
        5: load_corners(pack_corners($urandom_range(0, 1023), $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023)));
        7: load_corners(pack_corners(0, 0, 639, 0, 639, 479, 0, 479));
        default: load_corners(pack_corners(
                   $urandom_range(0, IN_WIDTH - 1), $urandom_range(0, IN_HEIGHT - 1),
                   $urandom_range(0, IN_WIDTH - 1), $urandom_range(0, IN_HEIGHT - 1),
                   $urandom_range(0, IN_WIDTH - 1), $urandom_range(0, IN_HEIGHT - 1),
                   $urandom_range(0, IN_WIDTH - 1), $urandom_range(0, IN_HEIGHT - 1)));
      endcase
      quiet = (phase == 7);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- quad_warp_address_generator.f -----
rtl/qwag_pkg.sv
rtl/qwag_bilerp.sv
rtl/quad_warp_address_generator.sv
test/warp_index_checker.sv
test/testbench.sv
